/* hdl/tipq_pkg.sv */
// Shared constants, codes and types of the timed item presentation queue.
package tipq_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int TIME_WIDTH  = 32;
   localparam int SLOT_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_FLUSH  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_NONE = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_DECIDE,
      S_SHIFT,
      S_DONE
   } state_type;

   // One queue entry as held by a cell.
   typedef struct packed {
      logic [TIME_WIDTH-1:0] start;
      logic [TIME_WIDTH-1:0] span;
      logic [SLOT_WIDTH-1:0] slot;
   } entry_type;

   // Per-cell controls from the sequencer.
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   // Per-cell compare results against the query time.
   typedef struct packed {
      logic future;
      logic match;
   } cell_flags_type;

endpackage

/* hdl/tipq_cell.sv */
// One cell of the entry chain: holds an entry, shifts toward the head, compares against time.
module tipq_cell (
   input  logic                                clock,
   input  tipq_pkg::cell_ctrl_type             ctrl,
   input  tipq_pkg::entry_type                 load_entry,
   input  tipq_pkg::entry_type                 next_entry,
   input  logic [tipq_pkg::TIME_WIDTH-1:0]     query_time,
   output tipq_pkg::entry_type                 entry,
   output tipq_pkg::cell_flags_type            flags
);

   tipq_pkg::entry_type             entry_ff;
   tipq_pkg::entry_type             entry_in;
   tipq_pkg::cell_flags_type        flags_ff;
   tipq_pkg::cell_flags_type        flags_in;
   logic [tipq_pkg::TIME_WIDTH-1:0] end_time;

   // Load a new item, take the neighbor's entry, or hold
   always_comb begin
      if (ctrl.load) begin
         entry_in = load_entry;
      end else if (ctrl.shift) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   // Compare the query time against [start, start+span), end wraps
   assign end_time = entry_ff.start + entry_ff.span;

   always_comb begin
      flags_in.future = query_time < entry_ff.start;
      flags_in.match  = !flags_in.future && (query_time < end_time);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flags_ff <= flags_in;
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

/* hdl/timed_item_presentation_queue.sv */
// Top level of the timed item presentation queue: sequencer, slot pool and cell chain.
//
// Usage:
//   Items enter on the req_ channel (valid/ready): opcode 0 inserts an item with
//   start time and span, opcode 1 queries at a presentation time, opcode 2 flushes.
//   Each item gives exactly one result on the rsp_ channel (valid/ready).
//   Live entries sit in a chain of cells, oldest at cell 0. A query compares every
//   cell against the time in parallel, then retires entries ahead of the chosen one
//   by shifting the chain toward the head one cell per cycle.
// Sequencing and handshake:
//   Insert, flush and queries that retire nothing: after the item is accepted,
//   the sequencer steps through evaluate, decide, finish into the output register.
//   A query that retires k entries, k at most QUEUE_DEPTH-1, shifts the chain k
//   times between decide and finish. req_ready is high only while no item is in
//   work; a finished result waits in the output register, so the next item is
//   accepted while the receiver stalls. A second result stays in the block until
//   the output register frees up.
// Reset:
//   Synchronous, active high. Clears the slot busy bits, the entry count, the
//   sequencer and the output valid. The queue starts empty; no clearing pass.
module timed_item_presentation_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_opcode,
   input  logic [tipq_pkg::TIME_WIDTH-1:0]      req_time_value,
   input  logic [tipq_pkg::TIME_WIDTH-1:0]      req_span,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [tipq_pkg::SLOT_WIDTH-1:0]      rsp_slot_index,
   output logic [tipq_pkg::TIME_WIDTH-1:0]      rsp_item_start,
   output logic [tipq_pkg::TIME_WIDTH-1:0]      rsp_item_span,
   output logic [tipq_pkg::COUNT_WIDTH-1:0]     rsp_entries_left
);

   localparam int D  = tipq_pkg::QUEUE_DEPTH;
   localparam int TW = tipq_pkg::TIME_WIDTH;
   localparam int SW = tipq_pkg::SLOT_WIDTH;
   localparam int CW = tipq_pkg::COUNT_WIDTH;

   // Sequencer
   tipq_pkg::state_type       state_ff;
   tipq_pkg::state_type       state_in;
   logic                      accept;
   logic                      decide_en;
   logic                      shift_en;
   logic                      done_en;
   logic                      out_free;

   // Held item
   logic [1:0]                opcode_ff;
   logic [1:0]                opcode_in;
   logic [TW-1:0]             time_ff;
   logic [TW-1:0]             time_in;
   logic [TW-1:0]             span_ff;
   logic [TW-1:0]             span_in;

   // Pool and chain bookkeeping
   logic [D-1:0]              busy_ff;
   logic [D-1:0]              busy_in;
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic [SW-1:0]             left_ff;
   logic [SW-1:0]             left_in;
   logic                      insert_load;

   // Staged result
   tipq_pkg::status_type      res_status_ff;
   tipq_pkg::status_type      res_status_in;
   logic [SW-1:0]             res_slot_ff;
   logic [SW-1:0]             res_slot_in;
   logic [TW-1:0]             res_start_ff;
   logic [TW-1:0]             res_start_in;
   logic [TW-1:0]             res_span_ff;
   logic [TW-1:0]             res_span_in;

   // Output register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   tipq_pkg::status_type      rsp_status_ff;
   tipq_pkg::status_type      rsp_status_in;
   logic [SW-1:0]             rsp_slot_ff;
   logic [SW-1:0]             rsp_slot_in;
   logic [TW-1:0]             rsp_start_ff;
   logic [TW-1:0]             rsp_start_in;
   logic [TW-1:0]             rsp_span_ff;
   logic [TW-1:0]             rsp_span_in;
   logic [CW-1:0]             rsp_left_ff;
   logic [CW-1:0]             rsp_left_in;

   // Chain
   tipq_pkg::entry_type       entries    [D];
   tipq_pkg::entry_type       next_entries [D];
   tipq_pkg::cell_flags_type  flags      [D];
   tipq_pkg::cell_ctrl_type   cell_ctrl  [D];
   tipq_pkg::entry_type       new_entry;

   // Decision
   logic                      head_ready;
   logic                      any_match;
   logic [SW-1:0]             last_match;
   logic                      any_future;
   logic [SW-1:0]             first_future;
   logic                      free_found;
   logic [SW-1:0]             free_slot;

   // Build the chain: each cell takes its neighbor toward the tail
   assign new_entry.start = time_ff;
   assign new_entry.span  = span_ff;
   assign new_entry.slot  = free_slot;

   for (genvar i = 0; i < D; i++) begin : g_cell
      if (i == D - 1) begin : g_last
         assign next_entries[i] = entries[i];
      end else begin : g_inner
         assign next_entries[i] = entries[i + 1];
      end

      assign cell_ctrl[i].load  = insert_load && (count_ff == CW'(i));
      assign cell_ctrl[i].shift = shift_en;

      tipq_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .load_entry (new_entry),
         .next_entry (next_entries[i]),
         .query_time (time_ff),
         .entry      (entries[i]),
         .flags      (flags[i])
      );
   end

   // Handshake status
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tipq_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = tipq_pkg::S_EVAL;
            end
         end
         tipq_pkg::S_EVAL: begin
            state_in = tipq_pkg::S_DECIDE;
         end
         tipq_pkg::S_DECIDE: begin
            if (left_in != '0) begin
               state_in = tipq_pkg::S_SHIFT;
            end else begin
               state_in = tipq_pkg::S_DONE;
            end
         end
         tipq_pkg::S_SHIFT: begin
            if (left_ff == SW'(1)) begin
               state_in = tipq_pkg::S_DONE;
            end
         end
         tipq_pkg::S_DONE: begin
            if (out_free) begin
               state_in = tipq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tipq_pkg::S_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      decide_en = 1'b0;
      shift_en  = 1'b0;
      done_en   = 1'b0;
      unique case (state_ff)
         tipq_pkg::S_IDLE:   req_ready = 1'b1;
         tipq_pkg::S_EVAL:   ;
         tipq_pkg::S_DECIDE: decide_en = 1'b1;
         tipq_pkg::S_SHIFT:  shift_en  = 1'b1;
         tipq_pkg::S_DONE:   done_en   = out_free;
         default:            ;
      endcase
   end

   // Scan the cell flags and the busy bits
   always_comb begin
      any_match    = 1'b0;
      last_match   = '0;
      any_future   = 1'b0;
      first_future = '0;
      free_found   = 1'b0;
      free_slot    = '0;
      for (int i = 0; i < D; i++) begin
         if ((CW'(i) < count_ff) && flags[i].match) begin
            any_match  = 1'b1;
            last_match = SW'(i);
         end
      end
      for (int i = D - 1; i >= 0; i--) begin
         if ((CW'(i) < count_ff) && flags[i].future) begin
            any_future   = 1'b1;
            first_future = SW'(i);
         end
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SW'(i);
         end
      end
   end

   assign head_ready = (count_ff != '0) && !flags[0].future;

   // Bookkeeping and staged result
   always_comb begin
      opcode_in     = opcode_ff;
      time_in       = time_ff;
      span_in       = span_ff;
      busy_in       = busy_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_start_in  = res_start_ff;
      res_span_in   = res_span_ff;
      insert_load   = 1'b0;

      // Capture the item
      if (accept) begin
         opcode_in = req_opcode;
         time_in   = req_time_value;
         span_in   = req_span;
      end

      // Decide the outcome of the item
      if (decide_en) begin
         res_status_in = tipq_pkg::STATUS_NONE;
         res_slot_in   = '0;
         res_start_in  = '0;
         res_span_in   = '0;
         left_in       = '0;
         unique case (opcode_ff)
            tipq_pkg::OP_INSERT: begin
               if (free_found) begin
                  insert_load          = 1'b1;
                  busy_in[free_slot]   = 1'b1;
                  count_in             = count_ff + CW'(1);
                  res_status_in        = tipq_pkg::STATUS_OK;
                  res_slot_in          = free_slot;
               end else begin
                  res_status_in = tipq_pkg::STATUS_FULL;
               end
            end
            tipq_pkg::OP_QUERY: begin
               if (head_ready) begin
                  if (any_match) begin
                     res_status_in = tipq_pkg::STATUS_OK;
                     res_slot_in   = entries[last_match].slot;
                     res_start_in  = entries[last_match].start;
                     res_span_in   = entries[last_match].span;
                     left_in       = last_match;
                  end else if (any_future) begin
                     left_in = first_future;
                  end else begin
                     busy_in  = '0;
                     count_in = '0;
                  end
               end
            end
            tipq_pkg::OP_FLUSH: begin
               busy_in       = '0;
               count_in      = '0;
               res_status_in = tipq_pkg::STATUS_OK;
            end
            default: ;
         endcase
      end

      // Retire the head entry and advance the chain
      if (shift_en) begin
         busy_in[entries[0].slot] = 1'b0;
         count_in                 = count_ff - CW'(1);
         left_in                  = left_ff - SW'(1);
      end
   end

   // Output register: load a finished result, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_span_in   = rsp_span_ff;
      rsp_left_in   = rsp_left_ff;
      if (done_en) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_slot_in   = res_slot_ff;
         rsp_start_in  = res_start_ff;
         rsp_span_in   = res_span_ff;
         rsp_left_in   = count_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tipq_pkg::S_IDLE;
         busy_ff      <= '0;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      opcode_ff     <= opcode_in;
      time_ff       <= time_in;
      span_ff       <= span_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_start_ff  <= res_start_in;
      res_span_ff   <= res_span_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_span_ff   <= rsp_span_in;
      rsp_left_ff   <= rsp_left_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_item_start   = rsp_start_ff;
   assign rsp_item_span    = rsp_span_ff;
   assign rsp_entries_left = rsp_left_ff;

endmodule
